>>> rtl/etg_pkg.sv
// ============================================================================
// etg_pkg
// Shared types and constants for the eased tween generator.
// ============================================================================
package etg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TIME_BITS = 32;
    localparam int ONE_W     = FRAC_BITS + 1;

    // Operation codes carried by an input beat.
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_PAUSE   = 2'd2;
    localparam logic [1:0] OP_RESUME  = 2'd3;

    // Easing curve codes.
    localparam logic [2:0] CRV_LINEAR  = 3'd0;
    localparam logic [2:0] CRV_QUAD_I  = 3'd1;
    localparam logic [2:0] CRV_QUAD_O  = 3'd2;
    localparam logic [2:0] CRV_QUAD_IO = 3'd3;
    localparam logic [2:0] CRV_CUBE_I  = 3'd4;
    localparam logic [2:0] CRV_CUBE_O  = 3'd5;
    localparam logic [2:0] CRV_CUBE_IO = 3'd6;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_START    = 3'd1;
    localparam logic [2:0] REG_END      = 3'd2;
    localparam logic [2:0] REG_DURATION = 3'd3;
    localparam logic [2:0] REG_CURVE    = 3'd4;

    // One classified command passed from the front to the back.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] delta;
        logic        ready;
    } cmd_t;

endpackage

>>> rtl/etg_front.sv
// ============================================================================
// etg_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ============================================================================
module etg_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [31:0]         delta,
    input  logic                cfg_ok,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output etg_pkg::cmd_t       cmd
);
    import etg_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       new_cmd;

    // Classification of the incoming beat.
    always_comb
    begin
        new_cmd.op    = operation;
        new_cmd.delta = delta;
        new_cmd.ready = cfg_ok;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");

endmodule

>>> rtl/etg_back.sv
// ============================================================================
// etg_back
// Executes commands: for a ready one updates the timer, divides for progress,
// eases and blends over a sequence of cycles, then holds the result for the consumer.
// ============================================================================
module etg_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  etg_pkg::cmd_t       cmd,
    input  logic                run_clear,
    input  logic signed [31:0]  start_value,
    input  logic signed [31:0]  end_value,
    input  logic [31:0]         duration,
    input  logic [2:0]          curve,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  value,
    output logic [31:0]         elapsed,
    output logic                is_paused,
    output logic                is_finished,
    output logic                status
);
    import etg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL1, S_MUL2, S_BL1, S_BL2, S_OUT
    } state_t;

    state_t                 state_reg;
    logic [31:0]            elapsed_reg;
    logic                   pause_reg;
    logic                   done_reg;
    logic [4:0]             cnt_reg;
    logic [32:0]            rem_reg;
    logic [ONE_W-1:0]       p_reg;
    logic [ONE_W-1:0]       x_reg;
    logic [ONE_W+1:0]       sq_reg;
    logic [ONE_W-1:0]       e_reg;
    logic signed [63:0]     acc_reg;
    logic signed [31:0]     value_reg;
    logic                   status_reg;

    localparam logic [ONE_W-1:0] ONE  = ONE_W'(1) << FRAC_BITS;
    localparam logic [ONE_W-1:0] HALF = ONE_W'(1) << (FRAC_BITS - 1);

    logic [32:0]        gap;
    logic [31:0]        remaining;
    logic [ONE_W+1:0]   v2;
    logic [2*ONE_W+3:0] prod;
    logic [ONE_W+1:0]   sq_next;
    logic [ONE_W-1:0]   e_next;
    logic               lower;

    assign cmd_ready   = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign value       = value_reg;
    assign elapsed     = elapsed_reg;
    assign is_paused   = pause_reg;
    assign is_finished = done_reg;
    assign status      = status_reg;
    assign remaining   = duration - elapsed_reg;
    assign gap         = {1'b0, duration} - rem_reg;
    assign lower       = (p_reg < HALF);
    assign v2          = {ONE - p_reg, 1'b0};

    // Squaring step: the first multiply squares x, the second forms the cube.
    always_comb
    begin
        prod    = '0;
        sq_next = '0;
        e_next  = '0;
        if (state_reg == S_MUL1)
        begin
            prod    = (2*ONE_W+4)'(x_reg) * (2*ONE_W+4)'(x_reg);
            sq_next = (ONE_W+2)'(prod >> FRAC_BITS);
        end
        else
        begin
            prod = (2*ONE_W+4)'(sq_reg) * (2*ONE_W+4)'(x_reg);
        end
        // Curve shaping from the square (MUL1) or cube (MUL2).
        case (curve)
            CRV_QUAD_I:  e_next = ONE_W'(sq_next);
            CRV_QUAD_O:  e_next = ONE - ONE_W'(sq_next);
            CRV_QUAD_IO: e_next = lower ? ONE_W'(prod >> (FRAC_BITS - 1))
                                        : ONE - ONE_W'(sq_next >> 1);
            CRV_CUBE_I:  e_next = ONE_W'(prod >> FRAC_BITS);
            CRV_CUBE_O:  e_next = ONE - ONE_W'(prod >> FRAC_BITS);
            CRV_CUBE_IO: e_next = lower ? ONE_W'((prod >> FRAC_BITS) << 2)
                                        : ONE - ONE_W'(prod >> (FRAC_BITS + 1));
            default:     e_next = p_reg;
        endcase
    end

    // Sequencer: timer update, restoring divide, ease, blend, hold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            elapsed_reg <= '0;
            pause_reg   <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= 1'b0;
            value_reg   <= '0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            p_reg       <= '0;
            x_reg       <= '0;
            sq_reg      <= '0;
            e_reg       <= '0;
            acc_reg     <= '0;
        end
        else if (run_clear)
        begin
            elapsed_reg <= '0;
            pause_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        status_reg <= !cmd.ready;
                        if (!cmd.ready)
                        begin
                            value_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                            cnt_reg   <= '0;
                            case (cmd.op)
                                OP_RESTART:
                                begin
                                    elapsed_reg <= '0;
                                    pause_reg   <= 1'b0;
                                    done_reg    <= 1'b0;
                                    rem_reg     <= '0;
                                    p_reg       <= '0;
                                end
                                OP_PAUSE:
                                begin
                                    pause_reg <= 1'b1;
                                    rem_reg   <= {1'b0, elapsed_reg};
                                    p_reg     <= '0;
                                end
                                OP_RESUME:
                                begin
                                    pause_reg <= 1'b0;
                                    rem_reg   <= {1'b0, elapsed_reg};
                                    p_reg     <= '0;
                                end
                                default:
                                begin
                                    p_reg <= '0;
                                    if (!pause_reg && !done_reg && cmd.delta != '0)
                                    begin
                                        if (cmd.delta >= remaining)
                                        begin
                                            elapsed_reg <= duration;
                                            done_reg    <= 1'b1;
                                            rem_reg     <= {1'b0, duration};
                                        end
                                        else
                                        begin
                                            elapsed_reg <= elapsed_reg + cmd.delta;
                                            rem_reg <= {1'b0, elapsed_reg + cmd.delta};
                                        end
                                    end
                                    else
                                    begin
                                        rem_reg <= {1'b0, elapsed_reg};
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_DIV:
                begin
                    // First step takes the integer bit, then one fraction bit per cycle.
                    if (cnt_reg == '0)
                    begin
                        if (rem_reg >= {1'b0, duration})
                        begin
                            rem_reg <= rem_reg - {1'b0, duration};
                            p_reg   <= ONE_W'(1);
                        end
                    end
                    else if (rem_reg >= gap)
                    begin
                        rem_reg <= rem_reg - gap;
                        p_reg   <= {p_reg[ONE_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[31:0], 1'b0};
                        p_reg   <= {p_reg[ONE_W-2:0], 1'b0};
                    end
                    if (cnt_reg == 5'(FRAC_BITS))
                    begin
                        state_reg <= S_MUL1;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_MUL1:
                begin
                    // Pick the operand that the curve squares or cubes.
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= '0;
                        case (curve)
                            CRV_QUAD_O, CRV_CUBE_O: x_reg <= ONE - p_reg;
                            CRV_QUAD_IO, CRV_CUBE_IO: x_reg <= lower ? p_reg
                                                           : ONE_W'(v2);
                            default: x_reg <= p_reg;
                        endcase
                    end
                    else
                    begin
                        sq_reg <= sq_next;
                        e_reg  <= e_next;
                        if (curve == CRV_CUBE_I || curve == CRV_CUBE_O ||
                            curve == CRV_CUBE_IO)
                        begin
                            state_reg <= S_MUL2;
                        end
                        else
                        begin
                            state_reg <= S_BL1;
                        end
                    end
                end
                S_MUL2:
                begin
                    e_reg     <= e_next;
                    state_reg <= S_BL1;
                end
                S_BL1:
                begin
                    acc_reg   <= 64'(start_value) * 64'(signed'({1'b0, ONE - e_reg}));
                    state_reg <= S_BL2;
                end
                S_BL2:
                begin
                    // Round half up, then take the integer part.
                    value_reg <= 32'((acc_reg + 64'(end_value) * 64'(signed'({1'b0, e_reg}))
                                 + 64'(HALF)) >>> FRAC_BITS);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && !status_reg |-> elapsed_reg <= duration)
        else $error("elapsed above duration");
    a_done_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && done_reg && !status_reg |-> elapsed_reg == duration)
        else $error("finished without saturation");
    a_prog_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL1 |-> p_reg <= ONE) else $error("progress above one");

endmodule

>>> rtl/eased_tween_generator.sv
// ============================================================================
// eased_tween_generator
// Millisecond tween timer with eased interpolation, APB configuration.
// ============================================================================
// Each input beat yields one result beat. A ready command goes through the back
// end in this order: the timer update, the bit-per-cycle progress divider,
// operand select and square plus a cube step for the cubic curves, the two
// blend steps with rounding, and the result offered until taken; a not-ready
// command goes straight to offering its result. A two-entry queue lets the
// next beats be accepted while one is in work or its result waits. Any write
// to a defined register clears elapsed time, pause and finished.
module eased_tween_generator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [31:0]         delta,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  value,
    output logic [31:0]         elapsed,
    output logic                is_paused,
    output logic                is_finished,
    output logic                status
);
    import etg_pkg::*;

    logic               enable_reg;
    logic signed [31:0] start_reg;
    logic signed [31:0] end_reg;
    logic [31:0]        duration_reg;
    logic [2:0]         curve_reg;
    logic               wr_en;
    logic               wr_hit;
    logic [2:0]         idx;
    logic               cfg_ok;
    logic               cmd_valid, cmd_ready;
    cmd_t               cmd;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign wr_hit = wr_en && (paddr[1:0] == 2'b00) && (idx <= REG_CURVE);
    assign cfg_ok = enable_reg && (duration_reg != '0) && (curve_reg <= CRV_CUBE_IO);

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            start_reg    <= '0;
            end_reg      <= '0;
            duration_reg <= 32'd1;
            curve_reg    <= CRV_LINEAR;
        end
        else if (wr_hit)
        begin
            case (idx)
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_START:    start_reg    <= pwdata;
                REG_END:      end_reg      <= pwdata;
                REG_DURATION: duration_reg <= pwdata;
                REG_CURVE:    curve_reg    <= pwdata[2:0];
                default:      enable_reg   <= enable_reg;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (idx)
            REG_ENABLE:   prdata = {31'd0, enable_reg};
            REG_START:    prdata = start_reg;
            REG_END:      prdata = end_reg;
            REG_DURATION: prdata = duration_reg;
            REG_CURVE:    prdata = {29'd0, curve_reg};
            default:      prdata = '0;
        endcase
    end

    etg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .delta     (delta),
        .cfg_ok    (cfg_ok),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    etg_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .run_clear   (wr_hit),
        .start_value (start_reg),
        .end_value   (end_reg),
        .duration    (duration_reg),
        .curve       (curve_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .elapsed     (elapsed),
        .is_paused   (is_paused),
        .is_finished (is_finished),
        .status      (status)
    );

endmodule

>>> tb/sv/eased_tween_generator_test.sv
// ============================================================================
// eased_tween_generator_test
// Self-checking bench for the eased tween generator.
// ============================================================================
// A queue of commands feeds a clocked driver and a clocked monitor checks every
// result beat against a fixed-point model of the timer and easing curves. The
// run walks through several register settings, written over APB when idle.
module eased_tween_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import etg_pkg::*;

    localparam longint ONE = 64'd1 << FRAC_BITS;
    localparam int TIMEOUT_CYCLES = 2000000;
    localparam logic [2:0] CRV_NONE   = 3'd7;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] delta;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        elapsed;
        logic               paused;
        logic               finished;
        logic               status;
    } tween_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] operation = OP_ADVANCE;
    logic [31:0] delta = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] value;
    logic [31:0] elapsed;
    logic is_paused, is_finished, status;

    eased_tween_generator dut (.*);

    always #1 clk = ~clk;

    // Model copy of the registers and run state.
    logic        cfg_enable = 1'b0;
    logic [31:0] cfg_start = '0, cfg_end = '0, cfg_duration = 32'd1;
    logic [2:0]  cfg_curve = CRV_LINEAR;
    logic [31:0] run_elapsed = '0;
    logic        run_paused = 1'b0, run_done = 1'b0;

    cmd_beat_t     pending_cmds[$];
    tween_result_t expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int cycle_count = 0;
    bit hold_done = 1'b0;
    int hold_cycles = 0;
    int phase = 0;

    function automatic longint unsigned sq_q(longint unsigned x);
        return (x * x) >> FRAC_BITS;
    endfunction

    function automatic longint unsigned cu_q(longint unsigned x);
        return (sq_q(x) * x) >> FRAC_BITS;
    endfunction

    function automatic longint unsigned eased_progress(logic [2:0] c, longint unsigned p);
        longint unsigned v;
        v = 2 * (ONE - p);
        case (c)
            CRV_QUAD_I:  return sq_q(p);
            CRV_QUAD_O:  return ONE - sq_q(ONE - p);
            CRV_QUAD_IO: return (p < ONE / 2) ? (2 * p * p) >> FRAC_BITS
                                              : ONE - ((v * v) >> (FRAC_BITS + 1));
            CRV_CUBE_I:  return cu_q(p);
            CRV_CUBE_O:  return ONE - cu_q(ONE - p);
            CRV_CUBE_IO: return (p < ONE / 2) ? 4 * cu_q(p) : ONE - (cu_q(v) >> 1);
            default:     return p;
        endcase
    endfunction

    // Advance the model by one command and return the result it gives.
    function automatic tween_result_t tween_step(cmd_beat_t c);
        tween_result_t r;
        bit ready;
        longint unsigned p, e;
        longint signed blend;
        ready = cfg_enable && cfg_duration != 0 && cfg_curve <= CRV_CUBE_IO;
        r = '0;
        if (ready) begin
            case (c.op)
                OP_RESTART:
                begin
                    run_elapsed = '0;
                    run_paused = 1'b0;
                    run_done = 1'b0;
                end
                OP_PAUSE:  run_paused = 1'b1;
                OP_RESUME: run_paused = 1'b0;
                default:
                begin
                    if (!run_paused && !run_done && c.delta != 0) begin
                        if (c.delta >= cfg_duration - run_elapsed) begin
                            run_elapsed = cfg_duration;
                            run_done = 1'b1;
                        end
                        else begin
                            run_elapsed = run_elapsed + c.delta;
                        end
                    end
                end
            endcase
            p = ({32'd0, run_elapsed} << FRAC_BITS) / {32'd0, cfg_duration};
            e = eased_progress(cfg_curve, p);
            blend = longint'(signed'(cfg_start)) * longint'(ONE - e)
                  + longint'(signed'(cfg_end)) * longint'(e) + ONE / 2;
            r.value = 32'(blend >>> FRAC_BITS);
        end
        r.elapsed = run_elapsed;
        r.paused = run_paused;
        r.finished = run_done;
        r.status = !ready;
        return r;
    endfunction

    // Driver: one beat at a time, with a random gap before each.
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_results.push_back(tween_step(pending_cmds.pop_front()));
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
                in_valid <= 1'b0;
            end
            else if (!in_valid && pending_cmds.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end
                else begin
                    in_valid <= 1'b1;
                    operation <= pending_cmds[0].op;
                    delta <= pending_cmds[0].delta;
                end
            end
        end
    end

    // Long receiver hold-off at the start of the fourth random phase, counted here.
    always @(posedge clk) begin
        if (phase == 3 && !hold_done) begin
            hold_cycles <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Monitor: random stalls and field-by-field checking.
    int stall_left = 0;
    always @(posedge clk) begin
        tween_result_t got, want;
        if (rst_n) begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready) begin
                got = '{value, elapsed, is_paused, is_finished, status};
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10) $display("unexpected result beat %p", got);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors <= errors + 1;
                        if (errors < 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
            end
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready) begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Timeout watchdog.
    always @(posedge clk) begin
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("eased_tween_generator_test NOT OK");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENABLE:   cfg_enable = data[0];
            REG_START:    cfg_start = data;
            REG_END:      cfg_end = data;
            REG_DURATION: cfg_duration = data;
            REG_CURVE:    cfg_curve = data[2:0];
            default:      return;
        endcase
        run_elapsed = '0;
        run_paused = 1'b0;
        run_done = 1'b0;
    endtask

    // Wait until the block has returned every result and gone quiet.
    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_cmd(logic [1:0] op, logic [31:0] d);
        pending_cmds.push_back('{op, d});
    endtask

    // Mostly well-formed runs: mostly advances, with random restarts, pauses and resumes.
    task automatic random_run(int count, logic [31:0] dur);
        int k;
        logic [1:0] op;
        logic [31:0] d;
        for (k = 0; k < count; k++) begin
            op = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : OP_ADVANCE;
            case ($urandom_range(0, 4))
                0:       d = $urandom;
                1:       d = 0;
                2:       d = dur;
                default: d = $urandom_range(0, (dur > 8) ? dur / 8 : 1);
            endcase
            push_cmd(op, d);
        end
    endtask

    logic [31:0] dur;
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Not ready after reset.
        push_cmd(OP_ADVANCE, 32'd5);
        push_cmd(OP_PAUSE, 0);
        drain();

        // Directed: extremes of values, the in-out curves, an invalid curve, special cases.
        apb_write(REG_ENABLE, 1);
        apb_write(REG_START, 32'h8000_0000);
        apb_write(REG_END, 32'h7FFF_FFFF);
        apb_write(REG_DURATION, 32'd100);
        apb_write(REG_CURVE, 32'(CRV_QUAD_IO));
        push_cmd(OP_ADVANCE, 0);
        push_cmd(OP_ADVANCE, 32'd50);
        push_cmd(OP_PAUSE, 0);
        push_cmd(OP_ADVANCE, 32'd10);
        push_cmd(OP_RESUME, 0);
        push_cmd(OP_ADVANCE, 32'hFFFF_FFFF);
        push_cmd(OP_PAUSE, 0);
        push_cmd(OP_ADVANCE, 32'd1);
        push_cmd(OP_RESTART, 0);
        push_cmd(OP_ADVANCE, 32'd49);
        push_cmd(OP_ADVANCE, 32'd1);
        drain();
        apb_write(REG_CURVE, 32'(CRV_NONE));
        push_cmd(OP_ADVANCE, 32'd3);
        drain();
        apb_write(REG_DURATION, 32'hFFFF_FFFF);
        apb_write(REG_CURVE, 32'(CRV_CUBE_IO));
        push_cmd(OP_ADVANCE, 32'h7FFF_FFFF);
        push_cmd(OP_ADVANCE, 32'h8000_0000);
        drain();
        apb_write(REG_DURATION, 0);
        push_cmd(OP_ADVANCE, 32'd1);
        drain();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);

        // Random phases across settings; one with a receiver hold-off.
        for (phase = 0; phase < 16; phase++) begin
            apb_write(REG_ENABLE, 32'($urandom_range(0, 9) != 0));
            apb_write(REG_START, $urandom);
            apb_write(REG_END, (phase % 4 == 0) ? 32'h7FFF_FFFF : $urandom);
            case (phase % 4)
                0:       dur = 32'd1;
                1:       dur = 32'hFFFF_FFFF;
                default: dur = $urandom_range(1, 5000);
            endcase
            apb_write(REG_DURATION, dur);
            apb_write(REG_CURVE, (phase < 14) ? phase % 7 : $urandom_range(0, 7));
            push_cmd(OP_RESTART, 0);
            random_run(52, dur);
            drain();
        end

        $display("Checked %0d result beats over directed special cases and 16 random settings,",
                 results_seen);
        $display("with random gaps on both sides and one long output stall.");
        if (errors == 0)
            $display("eased_tween_generator_test OK");
        else
            $display("eased_tween_generator_test NOT OK");
        $finish;
    end

endmodule
